>>> hw/rtl/i2csm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2csm_pkg
// Types and constants shared by the single-master I2C controller.
// ----------------------------------------------------------------------------
package i2csm_pkg;

   localparam int unsigned OP_W      = 3;
   localparam int unsigned BYTE_W    = 8;
   localparam int unsigned HALF_W    = 16;
   localparam int unsigned STRETCH_W = 24;
   localparam int unsigned BITCNT_W  = 4;
   localparam int unsigned CSR_ADDR_W = 1;
   localparam int unsigned CSR_DATA_W = 24;

   localparam logic [HALF_W-1:0]    HALF_BIT_RESET = 16'd500;
   localparam logic [STRETCH_W-1:0] STRETCH_RESET  = 24'd2000000;
   localparam logic [BITCNT_W-1:0]  BITS_PER_BYTE  = 4'd8;

   // opcodes as they arrive on the request channel
   localparam logic [OP_W-1:0] OP_NONE  = 3'd0;
   localparam logic [OP_W-1:0] OP_START = 3'd1;
   localparam logic [OP_W-1:0] OP_WRITE = 3'd2;
   localparam logic [OP_W-1:0] OP_READ  = 3'd3;
   localparam logic [OP_W-1:0] OP_STOP  = 3'd4;

   typedef enum logic [2:0] {
      CMD_NONE,
      CMD_START,
      CMD_WRITE,
      CMD_READ,
      CMD_STOP
   } cmd_type;

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_ST_CHK,
      PH_HB1,
      PH_STR,
      PH_HB2,
      PH_ST_HOLD,
      PH_SP_CHK
   } phase_type;

   typedef enum logic [2:0] {
      CX_START,
      CX_WBIT,
      CX_WACK,
      CX_RBIT,
      CX_RACK,
      CX_STOP
   } ctx_type;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_HALF_BIT = 1'b0,
      CSR_STRETCH  = 1'b1
   } csr_addr_type;

   typedef struct packed {
      cmd_type             cmd;
      logic [BYTE_W-1:0]   data_byte;
      logic                send_ack;
      logic                scl_level;
      logic                sda_level;
   } item_type;

   typedef struct packed {
      logic                scl_pull_low;
      logic                sda_pull_low;
      logic                busy_res;
      logic                done_res;
      logic [BYTE_W-1:0]   read_byte;
      logic                timed_out;
      logic                sda_blocked;
      logic                no_ack;
   } result_type;

   typedef struct packed {
      logic [HALF_W-1:0]    half_bit_ticks;
      logic [STRETCH_W-1:0] stretch_timeout_ticks;
   } cfg_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

>>> hw/rtl/i2csm_ifs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2csm channel interfaces
// Request, response and register-write channels with valid/ready.
// ----------------------------------------------------------------------------
interface i2csm_req_if;
   logic                      valid;
   logic                      ready;
   logic [i2csm_pkg::OP_W-1:0]   op;
   logic [i2csm_pkg::BYTE_W-1:0] data_byte;
   logic                      send_ack;
   logic                      scl_level;
   logic                      sda_level;

   modport source (output valid, op, data_byte, send_ack, scl_level, sda_level,
                   input ready);
   modport sink (input valid, op, data_byte, send_ack, scl_level, sda_level,
                 output ready);
   modport monitor (input valid, ready, op, data_byte, send_ack, scl_level,
                    sda_level);
endinterface

interface i2csm_rsp_if;
   logic                      valid;
   logic                      ready;
   logic                      scl_pull_low;
   logic                      sda_pull_low;
   logic                      busy_res;
   logic                      done_res;
   logic [i2csm_pkg::BYTE_W-1:0] read_byte;
   logic                      timed_out;
   logic                      sda_blocked;
   logic                      no_ack;

   modport source (output valid, scl_pull_low, sda_pull_low, busy_res, done_res,
                   read_byte, timed_out, sda_blocked, no_ack, input ready);
   modport sink (input valid, scl_pull_low, sda_pull_low, busy_res, done_res,
                 read_byte, timed_out, sda_blocked, no_ack, output ready);
   modport monitor (input valid, ready, scl_pull_low, sda_pull_low, busy_res,
                    done_res, read_byte, timed_out, sda_blocked, no_ack);
endinterface

interface i2csm_csr_if;
   logic                          valid;
   logic                          ready;
   logic [i2csm_pkg::CSR_ADDR_W-1:0] addr;
   logic [i2csm_pkg::CSR_DATA_W-1:0] wdata;

   modport source (output valid, addr, wdata, input ready);
   modport sink (input valid, addr, wdata, output ready);
   modport monitor (input valid, ready, addr, wdata);
endinterface

>>> hw/rtl/i2csm_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2csm_front
// Takes request beats, decodes the opcode and pushes items into the queue.
// ----------------------------------------------------------------------------
module i2csm_front (
   i2csm_req_if.sink                   req_chan,
   input  i2csm_pkg::queue_status_type q_status,
   output logic                        push_valid,
   output i2csm_pkg::item_type         push_item
);
   import i2csm_pkg::*;

   cmd_type cmd;

   // reserved opcodes behave like none
   always_comb begin
      case (req_chan.op)
         OP_START: cmd = CMD_START;
         OP_WRITE: cmd = CMD_WRITE;
         OP_READ:  cmd = CMD_READ;
         OP_STOP:  cmd = CMD_STOP;
         default:  cmd = CMD_NONE;
      endcase
   end

   assign req_chan.ready = !q_status.full;
   assign push_valid     = req_chan.valid && !q_status.full;

   always_comb begin
      push_item.cmd       = cmd;
      push_item.data_byte = req_chan.data_byte;
      push_item.send_ack  = req_chan.send_ack;
      push_item.scl_level = req_chan.scl_level;
      push_item.sda_level = req_chan.sda_level;
   end

endmodule

>>> hw/rtl/i2csm_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2csm_queue
// Small FIFO of decoded items between the front end and the bus engine.
// ----------------------------------------------------------------------------
module i2csm_queue #(
   parameter int unsigned DEPTH = 2
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         push_valid,
   input  i2csm_pkg::item_type          push_item,
   input  logic                         pop,
   output i2csm_pkg::item_type          head_item,
   output i2csm_pkg::queue_status_type  q_status
);
   import i2csm_pkg::*;

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   item_type          entry_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              do_push;
   logic              do_pop;

   assign q_status.full  = (count_ff == FULL_CNT);
   assign q_status.empty = (count_ff == '0);
   assign do_push = push_valid && !q_status.full;
   assign do_pop  = pop && !q_status.empty;
   assign head_item = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

>>> hw/rtl/i2csm_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2csm_engine
// Bus sequencer: one tick per item, with a registered response stage.
// ----------------------------------------------------------------------------
module i2csm_engine (
   input  logic                         clock,
   input  logic                         reset,
   input  i2csm_pkg::cfg_type           cfg,
   input  i2csm_pkg::item_type          head_item,
   input  i2csm_pkg::queue_status_type  q_status,
   output logic                         pop,
   i2csm_rsp_if.source                  rsp_chan
);
   import i2csm_pkg::*;

   phase_type              phase_ff, phase_in;
   ctx_type                ctx_ff, ctx_in;
   logic [BITCNT_W-1:0]    bit_ff, bit_in, bit_next;
   logic [BYTE_W-1:0]      shift_ff, shift_in, shift_rx;
   logic [HALF_W-1:0]      hb_ff, hb_in, hb_inc;
   logic [STRETCH_W-1:0]   str_ff, str_in;
   logic                   ack_ff, ack_in;
   logic                   timed_out_ff, timed_out_in;
   logic                   blocked_ff, blocked_in;
   logic                   no_ack_ff, no_ack_in;
   logic                   scl_drv_ff, scl_drv_in;
   logic                   sda_drv_ff, sda_drv_in;
   logic [BYTE_W-1:0]      rx_ff, rx_in;
   logic                   hb_over;
   logic                   done;
   logic                   rsp_valid_ff;
   result_type             rsp_data_ff, result;

   // a tick is taken when the response slot is free or being drained
   assign pop = !q_status.empty && (!rsp_valid_ff || rsp_chan.ready);

   always_comb begin
      phase_in     = phase_ff;
      ctx_in       = ctx_ff;
      bit_in       = bit_ff;
      shift_in     = shift_ff;
      hb_in        = hb_ff;
      str_in       = str_ff;
      ack_in       = ack_ff;
      timed_out_in = timed_out_ff;
      blocked_in   = blocked_ff;
      no_ack_in    = no_ack_ff;
      scl_drv_in   = scl_drv_ff;
      sda_drv_in   = sda_drv_ff;
      rx_in        = rx_ff;
      done         = 1'b0;
      // saturating half-bit counter, compared after the increment
      hb_inc   = (hb_ff == '1) ? hb_ff : hb_ff + HALF_W'(1);
      hb_over  = (hb_inc >= cfg.half_bit_ticks);
      bit_next = bit_ff + BITCNT_W'(1);
      shift_rx = {shift_ff[BYTE_W-2:0], head_item.sda_level};

      case (phase_ff)
         PH_IDLE: begin
            case (head_item.cmd)
               CMD_START: begin
                  timed_out_in = 1'b0;
                  blocked_in   = 1'b0;
                  no_ack_in    = 1'b0;
                  shift_in     = head_item.data_byte;
                  sda_drv_in   = 1'b0;
                  phase_in     = PH_ST_CHK;
               end
               CMD_WRITE: begin
                  bit_in     = '0;
                  sda_drv_in = !head_item.data_byte[BYTE_W-1];
                  shift_in   = {head_item.data_byte[BYTE_W-2:0], 1'b0};
                  ctx_in     = CX_WBIT;
                  hb_in      = '0;
                  phase_in   = PH_HB1;
               end
               CMD_READ: begin
                  sda_drv_in = 1'b0;
                  bit_in     = '0;
                  shift_in   = '0;
                  ack_in     = head_item.send_ack;
                  ctx_in     = CX_RBIT;
                  hb_in      = '0;
                  phase_in   = PH_HB1;
               end
               CMD_STOP: begin
                  sda_drv_in = 1'b1;
                  ctx_in     = CX_STOP;
                  hb_in      = '0;
                  phase_in   = PH_HB1;
               end
               default: ;
            endcase
         end
         PH_ST_CHK: begin
            if (!head_item.sda_level) begin
               blocked_in = 1'b1;
            end
            ctx_in   = CX_START;
            hb_in    = '0;
            phase_in = PH_HB1;
         end
         PH_HB1: begin
            hb_in = hb_inc;
            if (hb_over) begin
               scl_drv_in = 1'b0;
               str_in     = '0;
               phase_in   = PH_STR;
            end
         end
         PH_STR: begin
            if (head_item.scl_level) begin
               hb_in    = '0;
               phase_in = PH_HB2;
            end else if (str_ff >= cfg.stretch_timeout_ticks) begin
               timed_out_in = 1'b1;
               hb_in        = '0;
               phase_in     = PH_HB2;
            end else begin
               str_in = str_ff + STRETCH_W'(1);
            end
         end
         PH_HB2: begin
            hb_in = hb_inc;
            if (hb_over) begin
               case (ctx_ff)
                  CX_START: begin
                     sda_drv_in = 1'b1;
                     hb_in      = '0;
                     phase_in   = PH_ST_HOLD;
                  end
                  CX_WBIT: begin
                     scl_drv_in = 1'b1;
                     bit_in     = bit_next;
                     hb_in      = '0;
                     phase_in   = PH_HB1;
                     if (bit_next >= BITS_PER_BYTE) begin
                        sda_drv_in = 1'b0;
                        ctx_in     = CX_WACK;
                     end else begin
                        sda_drv_in = !shift_ff[BYTE_W-1];
                        shift_in   = {shift_ff[BYTE_W-2:0], 1'b0};
                        ctx_in     = CX_WBIT;
                     end
                  end
                  CX_WACK: begin
                     if (head_item.sda_level) begin
                        no_ack_in = 1'b1;
                     end
                     scl_drv_in = 1'b1;
                     phase_in   = PH_IDLE;
                     done       = 1'b1;
                  end
                  CX_RBIT: begin
                     shift_in   = shift_rx;
                     scl_drv_in = 1'b1;
                     bit_in     = bit_next;
                     hb_in      = '0;
                     phase_in   = PH_HB1;
                     if (bit_next >= BITS_PER_BYTE) begin
                        sda_drv_in = ack_ff;
                        ctx_in     = CX_RACK;
                     end else begin
                        ctx_in = CX_RBIT;
                     end
                  end
                  CX_RACK: begin
                     scl_drv_in = 1'b1;
                     rx_in      = shift_ff;
                     phase_in   = PH_IDLE;
                     done       = 1'b1;
                  end
                  CX_STOP: begin
                     sda_drv_in = 1'b0;
                     phase_in   = PH_SP_CHK;
                  end
                  default: phase_in = PH_IDLE;
               endcase
            end
         end
         PH_ST_HOLD: begin
            hb_in = hb_inc;
            if (hb_over) begin
               scl_drv_in = 1'b1;
               bit_in     = '0;
               sda_drv_in = !shift_ff[BYTE_W-1];
               shift_in   = {shift_ff[BYTE_W-2:0], 1'b0};
               ctx_in     = CX_WBIT;
               hb_in      = '0;
               phase_in   = PH_HB1;
            end
         end
         PH_SP_CHK: begin
            if (!head_item.sda_level) begin
               blocked_in = 1'b1;
            end
            phase_in = PH_IDLE;
            done     = 1'b1;
         end
         default: phase_in = PH_IDLE;
      endcase

      result.scl_pull_low = scl_drv_in;
      result.sda_pull_low = sda_drv_in;
      result.busy_res     = (phase_in != PH_IDLE);
      result.done_res     = done;
      result.read_byte    = rx_in;
      result.timed_out    = timed_out_in;
      result.sda_blocked  = blocked_in;
      result.no_ack       = no_ack_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         ctx_ff       <= CX_START;
         bit_ff       <= '0;
         shift_ff     <= '0;
         hb_ff        <= '0;
         str_ff       <= '0;
         ack_ff       <= 1'b0;
         timed_out_ff <= 1'b0;
         blocked_ff   <= 1'b0;
         no_ack_ff    <= 1'b0;
         scl_drv_ff   <= 1'b0;
         sda_drv_ff   <= 1'b0;
         rx_ff        <= '0;
      end else if (pop) begin
         phase_ff     <= phase_in;
         ctx_ff       <= ctx_in;
         bit_ff       <= bit_in;
         shift_ff     <= shift_in;
         hb_ff        <= hb_in;
         str_ff       <= str_in;
         ack_ff       <= ack_in;
         timed_out_ff <= timed_out_in;
         blocked_ff   <= blocked_in;
         no_ack_ff    <= no_ack_in;
         scl_drv_ff   <= scl_drv_in;
         sda_drv_ff   <= sda_drv_in;
         rx_ff        <= rx_in;
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (pop) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.scl_pull_low = rsp_data_ff.scl_pull_low;
   assign rsp_chan.sda_pull_low = rsp_data_ff.sda_pull_low;
   assign rsp_chan.busy_res     = rsp_data_ff.busy_res;
   assign rsp_chan.done_res     = rsp_data_ff.done_res;
   assign rsp_chan.read_byte    = rsp_data_ff.read_byte;
   assign rsp_chan.timed_out    = rsp_data_ff.timed_out;
   assign rsp_chan.sda_blocked  = rsp_data_ff.sda_blocked;
   assign rsp_chan.no_ack       = rsp_data_ff.no_ack;

endmodule

>>> hw/rtl/i2c_single_master_controller_top.sv
`timescale 1ns / 1ps
// A request beat is registered in the item queue, then in the response register.
// Throughput: one beat per cycle while responses are taken; one bus tick per beat.
// A two-entry item queue separates request intake from the bus sequencer.
// Reset (synchronous): bus state idle, both lines released, flags and read byte
// cleared, half_bit_ticks back to 500 and stretch_timeout_ticks to 2000000.
// ----------------------------------------------------------------------------
// i2c_single_master_controller_top
// Single-master I2C controller: front end, item queue and bus sequencer.
// ----------------------------------------------------------------------------
module i2c_single_master_controller_top #(
   parameter int unsigned QUEUE_DEPTH = 2
) (
   input  logic         clock,
   input  logic         reset,
   i2csm_req_if.sink    req_chan,
   i2csm_rsp_if.source  rsp_chan,
   i2csm_csr_if.sink    csr_chan
);
   import i2csm_pkg::*;

   cfg_type          cfg_ff, cfg_in;
   queue_status_type q_status;
   item_type         push_item;
   item_type         head_item;
   logic             push_valid;
   logic             pop;

   assign csr_chan.ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_chan.valid) begin
         case (csr_addr_type'(csr_chan.addr))
            CSR_HALF_BIT: cfg_in.half_bit_ticks = csr_chan.wdata[HALF_W-1:0];
            CSR_STRETCH:  cfg_in.stretch_timeout_ticks = csr_chan.wdata[STRETCH_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.half_bit_ticks        <= HALF_BIT_RESET;
         cfg_ff.stretch_timeout_ticks <= STRETCH_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   i2csm_front u_front (
      .req_chan   (req_chan),
      .q_status   (q_status),
      .push_valid (push_valid),
      .push_item  (push_item)
   );

   i2csm_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_item  (push_item),
      .pop        (pop),
      .head_item  (head_item),
      .q_status   (q_status)
   );

   i2csm_engine u_engine (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .head_item (head_item),
      .q_status  (q_status),
      .pop       (pop),
      .rsp_chan  (rsp_chan)
   );

endmodule

>>> hw/rtl/i2csm_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2csm_checker
// Port-level checks on the controller, attached to the top level by bind.
// ----------------------------------------------------------------------------
module i2csm_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic                         rsp_busy,
   input logic                         rsp_done,
   input logic [i2csm_pkg::BYTE_W-1:0] rsp_read_byte,
   input logic                         csr_valid,
   input logic                         csr_ready
);

   // a stalled response beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid
         && $stable(rsp_read_byte) && $stable(rsp_done)
         && $stable(rsp_busy))
      else $error("response beat changed while stalled");

   // a finishing tick never reports busy
   a_done_not_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_done && rsp_busy))
      else $error("done and busy in the same beat");

   // no response beat straight out of reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   // register writes are never back-pressured
   a_csr_ready: assert property (@(posedge clock) disable iff (reset)
      csr_valid |-> csr_ready)
      else $error("register write stalled");

endmodule

bind i2c_single_master_controller_top i2csm_checker u_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_chan.valid),
   .rsp_ready     (rsp_chan.ready),
   .rsp_busy      (rsp_chan.busy_res),
   .rsp_done      (rsp_chan.done_res),
   .rsp_read_byte (rsp_chan.read_byte),
   .csr_valid     (csr_chan.valid),
   .csr_ready     (csr_chan.ready)
);

>>> test/i2c_single_master_controller_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2c_single_master_controller_top_test
// Drives bus ticks into the single-master I2C controller from a backlog filled
// with start/write/read/stop transfers against a simple slave model, with
// random gaps on both channels. Every response beat is checked field by field
// against a bit-accurate bus predictor, over several timing settings.
// ----------------------------------------------------------------------------
module i2c_single_master_controller_top_test;
   import i2csm_pkg::*;

   localparam int unsigned CYCLE_LIMIT = 1_000_000;
   localparam int unsigned DRAIN_LIMIT = 1000;

   typedef struct packed {
      logic [OP_W-1:0]   op;
      logic [BYTE_W-1:0] data_byte;
      logic              send_ack;
      logic              scl_level;
      logic              sda_level;
   } tick_item_type;

   typedef struct {
      logic [HALF_W-1:0]    half_ticks;
      logic [STRETCH_W-1:0] stretch_limit;
      phase_type            phase;
      ctx_type              pulse_kind;
      logic [BITCNT_W-1:0]  bits_done;
      logic [BYTE_W-1:0]    shifter;
      logic [HALF_W-1:0]    half_cnt;
      logic [STRETCH_W-1:0] stretch_cnt;
      logic                 ack_bit;
      logic                 timed_out;
      logic                 sda_blocked;
      logic                 no_ack;
      logic                 scl_drv;
      logic                 sda_drv;
      logic [BYTE_W-1:0]    rx_byte;
   } bus_model_type;

   typedef enum int {
      SLV_NORMAL,
      SLV_SDA_LOW,
      SLV_SCL_LOW,
      SLV_NO_ACK
   } slave_mode_type;

   logic clock;
   logic reset;

   i2csm_req_if req_bus ();
   i2csm_rsp_if rsp_bus ();
   i2csm_csr_if csr_bus ();

   i2c_single_master_controller_top dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus),
      .csr_chan (csr_bus)
   );

   tick_item_type  tick_backlog[$];
   result_type     bus_view_due[$];
   bus_model_type  gen_bus;
   bus_model_type  chk_bus;
   slave_mode_type slave_mode;
   int unsigned stretch_left;
   int unsigned ticks_made;
   int unsigned ticks_checked;
   int unsigned cmds_done;
   int unsigned settings_run;
   int unsigned mismatches;
   int unsigned cycle_count;
   int unsigned req_gap;
   int unsigned rsp_gap;
   bit          calm;

   // ------------------------------------------------------------------------
   // bus predictor
   // ------------------------------------------------------------------------
   function automatic bus_model_type bus_at_reset();
      bus_model_type m;
      m.half_ticks    = HALF_BIT_RESET;
      m.stretch_limit = STRETCH_RESET;
      m.phase         = PH_IDLE;
      m.pulse_kind    = CX_START;
      m.bits_done     = '0;
      m.shifter       = '0;
      m.half_cnt      = '0;
      m.stretch_cnt   = '0;
      m.ack_bit       = 1'b0;
      m.timed_out     = 1'b0;
      m.sda_blocked   = 1'b0;
      m.no_ack        = 1'b0;
      m.scl_drv       = 1'b0;
      m.sda_drv       = 1'b0;
      m.rx_byte       = '0;
      return m;
   endfunction

   function automatic void apply_reg(ref bus_model_type m, input logic [CSR_ADDR_W-1:0] idx,
                                     input logic [CSR_DATA_W-1:0] val);
      case (idx)
         CSR_HALF_BIT: m.half_ticks = val[HALF_W-1:0];
         CSR_STRETCH:  m.stretch_limit = val[STRETCH_W-1:0];
         default: ;
      endcase
   endfunction

   // next address/data bit onto SDA, released for a one
   function automatic void place_bit(ref bus_model_type m);
      m.sda_drv = !m.shifter[BYTE_W-1];
      m.shifter = m.shifter << 1;
   endfunction

   function automatic void open_pulse(ref bus_model_type m, input ctx_type kind);
      m.pulse_kind = kind;
      m.half_cnt   = '0;
      m.phase      = PH_HB1;
   endfunction

   // counter saturates, so a zero setting acts as one
   function automatic logic half_elapsed(ref bus_model_type m);
      if (m.half_cnt != '1) m.half_cnt = m.half_cnt + 1'b1;
      return m.half_cnt >= m.half_ticks;
   endfunction

   function automatic result_type bus_tick(ref bus_model_type m, input tick_item_type it);
      result_type r;
      logic       fin;
      fin = 1'b0;
      case (m.phase)
         PH_IDLE: begin
            if (it.op == OP_START) begin
               m.timed_out   = 1'b0;
               m.sda_blocked = 1'b0;
               m.no_ack      = 1'b0;
               m.shifter     = it.data_byte;
               m.sda_drv     = 1'b0;
               m.phase       = PH_ST_CHK;
            end else if (it.op == OP_WRITE) begin
               m.shifter   = it.data_byte;
               m.bits_done = '0;
               place_bit(m);
               open_pulse(m, CX_WBIT);
            end else if (it.op == OP_READ) begin
               m.sda_drv   = 1'b0;
               m.bits_done = '0;
               m.shifter   = '0;
               m.ack_bit   = it.send_ack;
               open_pulse(m, CX_RBIT);
            end else if (it.op == OP_STOP) begin
               m.sda_drv = 1'b1;
               open_pulse(m, CX_STOP);
            end
         end
         PH_ST_CHK: begin
            if (!it.sda_level) m.sda_blocked = 1'b1;
            open_pulse(m, CX_START);
         end
         PH_HB1: begin
            if (half_elapsed(m)) begin
               m.scl_drv     = 1'b0;
               m.stretch_cnt = '0;
               m.phase       = PH_STR;
            end
         end
         PH_STR: begin
            if (it.scl_level) begin
               m.half_cnt = '0;
               m.phase    = PH_HB2;
            end else if (m.stretch_cnt >= m.stretch_limit) begin
               m.timed_out = 1'b1;
               m.half_cnt  = '0;
               m.phase     = PH_HB2;
            end else begin
               m.stretch_cnt = m.stretch_cnt + 1'b1;
            end
         end
         PH_HB2: begin
            if (half_elapsed(m)) begin
               // end of the SCL high time: sample, then move on by pulse kind
               case (m.pulse_kind)
                  CX_START: begin
                     m.sda_drv  = 1'b1;
                     m.half_cnt = '0;
                     m.phase    = PH_ST_HOLD;
                  end
                  CX_WBIT: begin
                     m.scl_drv   = 1'b1;
                     m.bits_done = m.bits_done + 1'b1;
                     if (m.bits_done >= BITS_PER_BYTE) begin
                        m.sda_drv = 1'b0;
                        open_pulse(m, CX_WACK);
                     end else begin
                        place_bit(m);
                        open_pulse(m, CX_WBIT);
                     end
                  end
                  CX_WACK: begin
                     if (it.sda_level) m.no_ack = 1'b1;
                     m.scl_drv = 1'b1;
                     m.phase   = PH_IDLE;
                     fin       = 1'b1;
                  end
                  CX_RBIT: begin
                     m.shifter   = {m.shifter[BYTE_W-2:0], it.sda_level};
                     m.scl_drv   = 1'b1;
                     m.bits_done = m.bits_done + 1'b1;
                     if (m.bits_done >= BITS_PER_BYTE) begin
                        m.sda_drv = m.ack_bit;
                        open_pulse(m, CX_RACK);
                     end else begin
                        open_pulse(m, CX_RBIT);
                     end
                  end
                  CX_RACK: begin
                     m.scl_drv = 1'b1;
                     m.rx_byte = m.shifter;
                     m.phase   = PH_IDLE;
                     fin       = 1'b1;
                  end
                  CX_STOP: begin
                     m.sda_drv = 1'b0;
                     m.phase   = PH_SP_CHK;
                  end
                  default: m.phase = PH_IDLE;
               endcase
            end
         end
         PH_ST_HOLD: begin
            if (half_elapsed(m)) begin
               m.scl_drv   = 1'b1;
               m.bits_done = '0;
               place_bit(m);
               open_pulse(m, CX_WBIT);
            end
         end
         PH_SP_CHK: begin
            if (!it.sda_level) m.sda_blocked = 1'b1;
            m.phase = PH_IDLE;
            fin     = 1'b1;
         end
         default: m.phase = PH_IDLE;
      endcase
      r.scl_pull_low = m.scl_drv;
      r.sda_pull_low = m.sda_drv;
      r.busy_res     = (m.phase != PH_IDLE);
      r.done_res     = fin;
      r.read_byte    = m.rx_byte;
      r.timed_out    = m.timed_out;
      r.sda_blocked  = m.sda_blocked;
      r.no_ack       = m.no_ack;
      return r;
   endfunction

   // ------------------------------------------------------------------------
   // checking
   // ------------------------------------------------------------------------
   task automatic flag_mismatch(input string what);
      mismatches++;
      $display("mismatch @%0t: %s", $realtime, what);
   endtask

   task automatic check_field(input string name, input logic [BYTE_W-1:0] got,
                              input logic [BYTE_W-1:0] want);
      if (got !== want)
         flag_mismatch($sformatf("beat %0d %s got %0h want %0h", ticks_checked, name,
                                 got, want));
   endtask

   // ------------------------------------------------------------------------
   // stimulus generation: the slave view of the bus follows a shadow predictor
   // ------------------------------------------------------------------------
   task automatic emit(input logic [OP_W-1:0] op, input logic [BYTE_W-1:0] data,
                       input logic ack);
      tick_item_type it;
      logic          scl;
      logic          sda;
      scl = !gen_bus.scl_drv;
      if (stretch_left != 0) begin
         scl = 1'b0;
         stretch_left--;
      end else if (gen_bus.phase == PH_STR && $urandom_range(0, 3) == 0) begin
         scl = 1'b0;
         stretch_left = $urandom_range(0, 11);
      end
      if (gen_bus.sda_drv) begin
         sda = 1'b0;
      end else if (gen_bus.phase == PH_HB2 && gen_bus.pulse_kind == CX_WACK) begin
         sda = ($urandom_range(0, 4) == 0);
      end else if (gen_bus.phase == PH_ST_CHK || gen_bus.phase == PH_SP_CHK) begin
         sda = ($urandom_range(0, 15) != 0);
      end else begin
         sda = 1'($urandom);
      end
      case (slave_mode)
         SLV_SDA_LOW: sda = 1'b0;
         SLV_SCL_LOW: scl = 1'b0;
         SLV_NO_ACK:  sda = !gen_bus.sda_drv;
         default: ;
      endcase
      it.op        = op;
      it.data_byte = data;
      it.send_ack  = ack;
      it.scl_level = scl;
      it.sda_level = sda;
      void'(bus_tick(gen_bus, it));
      tick_backlog.push_back(it);
      ticks_made++;
   endtask

   // a command from idle, then bus ticks until it is over; stray commands ride along
   task automatic run_command(input logic [OP_W-1:0] op, input logic [BYTE_W-1:0] data,
                              input logic ack);
      logic [OP_W-1:0] stray;
      emit(op, data, ack);
      while (gen_bus.phase != PH_IDLE) begin
         stray = ($urandom_range(0, 7) == 0) ? OP_W'($urandom) : OP_NONE;
         emit(stray, BYTE_W'($urandom), 1'($urandom));
      end
   endtask

   task automatic pause();
      logic [OP_W-1:0] stray;
      repeat ($urandom_range(0, 2)) begin
         stray = OP_NONE;
         if ($urandom_range(0, 5) == 0)
            stray = OP_W'($urandom_range(int'(OP_STOP) + 1, (1 << OP_W) - 1));
         emit(stray, BYTE_W'($urandom), 1'($urandom));
      end
   endtask

   task automatic run_transfer();
      slave_mode = SLV_NORMAL;
      if ($urandom_range(0, 9) == 0) begin
         slave_mode = slave_mode_type'($urandom_range(1, 3));
         // a slave that never lets go of SCL only makes sense with a short timeout
         if (slave_mode == SLV_SCL_LOW && gen_bus.stretch_limit > 64) slave_mode = SLV_NORMAL;
      end
      if ($urandom_range(0, 7) != 0) run_command(OP_START, BYTE_W'($urandom), 1'($urandom));
      repeat ($urandom_range(1, 3)) begin
         pause();
         if ($urandom_range(0, 1) == 0)
            run_command(OP_WRITE, BYTE_W'($urandom), 1'($urandom));
         else
            run_command(OP_READ, BYTE_W'($urandom), 1'($urandom));
      end
      pause();
      if ($urandom_range(0, 7) != 0) run_command(OP_STOP, BYTE_W'($urandom), 1'($urandom));
      pause();
      slave_mode = SLV_NORMAL;
   endtask

   task automatic run_phase(input int unsigned budget);
      int unsigned first;
      first = ticks_made;
      while (ticks_made - first < budget) run_transfer();
   endtask

   // wait until every queued tick has come back and the pipeline is quiet
   task automatic settle();
      while (tick_backlog.size() != 0 || req_bus.valid || bus_view_due.size() != 0)
         @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   task automatic write_reg(input csr_addr_type idx, input logic [CSR_DATA_W-1:0] val);
      @(posedge clock);
      csr_bus.valid <= 1'b1;
      csr_bus.addr  <= idx;
      csr_bus.wdata <= val;
      do @(posedge clock); while (!csr_bus.ready);
      csr_bus.valid <= 1'b0;
      apply_reg(gen_bus, idx, val);
   endtask

   task automatic set_timing(input logic [HALF_W-1:0] half, input logic [STRETCH_W-1:0] limit);
      logic [CSR_DATA_W-1:0] word;
      settle();
      // upper bits of the half-bit write are don't-care and get junk
      word = CSR_DATA_W'($urandom);
      word[HALF_W-1:0] = half;
      write_reg(CSR_HALF_BIT, word);
      write_reg(CSR_STRETCH, CSR_DATA_W'(limit));
      settings_run++;
   endtask

   // ------------------------------------------------------------------------
   // clock, driver, response side, scoreboard, watchdog
   // ------------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      tick_item_type beat;
      if (reset) begin
         req_bus.valid <= 1'b0;
         req_gap       <= 0;
      end else if (!req_bus.valid || req_bus.ready) begin
         if (req_gap != 0) begin
            req_bus.valid <= 1'b0;
            req_gap       <= req_gap - 1;
         end else if (!calm && $urandom_range(0, 11) == 0) begin
            req_bus.valid <= 1'b0;
            req_gap       <= $urandom_range(0, 8);
         end else if (tick_backlog.size() != 0) begin
            beat = tick_backlog.pop_front();
            req_bus.op        <= beat.op;
            req_bus.data_byte <= beat.data_byte;
            req_bus.send_ack  <= beat.send_ack;
            req_bus.scl_level <= beat.scl_level;
            req_bus.sda_level <= beat.sda_level;
            req_bus.valid     <= 1'b1;
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         rsp_gap       <= 0;
      end else if (rsp_gap != 0) begin
         rsp_bus.ready <= 1'b0;
         rsp_gap       <= rsp_gap - 1;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
         rsp_bus.ready <= 1'b0;
         rsp_gap       <= $urandom_range(0, 8);
      end else begin
         rsp_bus.ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      tick_item_type beat;
      result_type    want;
      if (!reset) begin
         if (csr_bus.valid && csr_bus.ready) apply_reg(chk_bus, csr_bus.addr, csr_bus.wdata);
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (bus_view_due.size() == 0) begin
               flag_mismatch("response beat with nothing outstanding");
            end else begin
               want = bus_view_due.pop_front();
               check_field("scl_pull_low", BYTE_W'(rsp_bus.scl_pull_low),
                           BYTE_W'(want.scl_pull_low));
               check_field("sda_pull_low", BYTE_W'(rsp_bus.sda_pull_low),
                           BYTE_W'(want.sda_pull_low));
               check_field("busy_res", BYTE_W'(rsp_bus.busy_res), BYTE_W'(want.busy_res));
               check_field("done_res", BYTE_W'(rsp_bus.done_res), BYTE_W'(want.done_res));
               check_field("read_byte", rsp_bus.read_byte, want.read_byte);
               check_field("timed_out", BYTE_W'(rsp_bus.timed_out), BYTE_W'(want.timed_out));
               check_field("sda_blocked", BYTE_W'(rsp_bus.sda_blocked),
                           BYTE_W'(want.sda_blocked));
               check_field("no_ack", BYTE_W'(rsp_bus.no_ack), BYTE_W'(want.no_ack));
               if (want.done_res) cmds_done++;
            end
            ticks_checked++;
         end
         if (req_bus.valid && req_bus.ready) begin
            beat.op        = req_bus.op;
            beat.data_byte = req_bus.data_byte;
            beat.send_ack  = req_bus.send_ack;
            beat.scl_level = req_bus.scl_level;
            beat.sda_level = req_bus.sda_level;
            bus_view_due.push_back(bus_tick(chk_bus, beat));
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // test sequence
   // ------------------------------------------------------------------------
   initial begin
      int unsigned spin;
      int          code;
      reset             = 1'b1;
      req_bus.valid     = 1'b0;
      req_bus.op        = OP_NONE;
      req_bus.data_byte = '0;
      req_bus.send_ack  = 1'b0;
      req_bus.scl_level = 1'b1;
      req_bus.sda_level = 1'b1;
      rsp_bus.ready     = 1'b0;
      csr_bus.valid     = 1'b0;
      csr_bus.addr      = CSR_HALF_BIT;
      csr_bus.wdata     = '0;
      gen_bus           = bus_at_reset();
      chk_bus           = bus_at_reset();
      slave_mode        = SLV_NORMAL;
      stretch_left      = 0;
      ticks_made        = 0;
      ticks_checked     = 0;
      cmds_done         = 0;
      settings_run      = 0;
      mismatches        = 0;
      cycle_count       = 0;
      req_gap           = 0;
      rsp_gap           = 0;
      calm              = 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // a stop at the reset timing, cut short by dropping to zero half bit mid-pulse
      emit(OP_STOP, 8'h00, 1'b0);
      repeat (24) emit(OP_NONE, 8'h00, 1'b0);

      // directed: zero half bit, zero stretch limit
      set_timing('0, '0);
      while (gen_bus.phase != PH_IDLE) emit(OP_NONE, 8'h00, 1'b0);
      emit(OP_NONE, 8'hFF, 1'b1);
      for (code = int'(OP_STOP) + 1; code < (1 << OP_W); code++)
         emit(OP_W'(code), 8'h00, 1'b0);
      slave_mode = SLV_SDA_LOW;
      run_command(OP_START, 8'hFF, 1'b0);
      slave_mode = SLV_SCL_LOW;
      run_command(OP_WRITE, 8'h00, 1'b1);
      slave_mode = SLV_NO_ACK;
      run_command(OP_WRITE, 8'hA5, 1'b0);
      slave_mode = SLV_NORMAL;
      run_command(OP_READ, 8'h00, 1'b1);
      run_command(OP_READ, 8'hFF, 1'b0);
      run_command(OP_START, 8'h00, 1'b1);
      run_command(OP_WRITE, 8'h5A, 1'b1);
      slave_mode = SLV_SDA_LOW;
      run_command(OP_STOP, 8'hFF, 1'b1);
      slave_mode = SLV_NORMAL;

      // random transfers over a spread of timings
      set_timing(16'd1, 24'd1);
      run_phase(60);
      set_timing(16'd2, 24'd6);
      run_phase(60);

      // a stretch with both channels flat out
      set_timing(16'd1, STRETCH_W'($urandom_range(0, 8)));
      calm = 1'b1;
      run_phase(60);
      // widest settings: the opening of a stop is enough to exercise them
      set_timing(16'hFFFF, 24'hFFFFFF);
      emit(OP_STOP, BYTE_W'($urandom), 1'($urandom));
      repeat (30) emit(OP_NONE, BYTE_W'($urandom), 1'($urandom));

      while (tick_backlog.size() != 0 || req_bus.valid) @(posedge clock);
      spin = 0;
      while (bus_view_due.size() != 0 && spin < DRAIN_LIMIT) begin
         @(posedge clock);
         spin++;
      end
      repeat (8) @(posedge clock);
      if (bus_view_due.size() != 0)
         flag_mismatch($sformatf("%0d expected beats never arrived", bus_view_due.size()));

      $display("run covered %0d bus ticks and %0d finished commands over %0d timing settings",
               ticks_checked, cmds_done, settings_run);
      $display("%0d mismatching fields or beats", mismatches);
      if (mismatches == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
